// ===== rtl/xnce_pkg.sv =====
// Shared types and constants for the XML numeric character escaper.
`default_nettype none
package xnce_pkg;

    // Character codes used by the classifier and the sequencer
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChLowA   = 8'h61;
    localparam logic [7:0] ChLowZ   = 8'h7A;
    localparam logic [7:0] ChUpA    = 8'h41;
    localparam logic [7:0] ChUpZ    = 8'h5A;
    localparam logic [7:0] ChDquote = 8'h22;
    localparam logic [7:0] ChSquote = 8'h27;
    localparam logic [7:0] ChAmp    = 8'h26;
    localparam logic [7:0] ChHash   = 8'h23;
    localparam logic [7:0] ChSemi   = 8'h3B;

    // Queue depth between the front and back parts
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Classified item handed from front to back
    typedef struct packed {
        logic       plain;    // byte passes unchanged
        logic [7:0] ch;       // raw byte
        logic       has_hund; // value >= 100
        logic       has_tens; // value >= 10
        logic [1:0] hund;     // hundreds digit
        logic [3:0] tens;     // tens digit
        logic [3:0] ones;     // ones digit
    } xnce_desc_t;

    // Back-end sequencer steps
    typedef enum logic [2:0] {
        ST_AMP,
        ST_HASH,
        ST_HUND,
        ST_TENS,
        ST_ONES,
        ST_SEMI
    } xnce_state_t;

endpackage
`default_nettype wire

// ===== rtl/xnce_front.sv =====
// Front part: classifies one byte and splits its value into decimal digits.
`default_nettype none
module xnce_front (
    input  wire logic [7:0]          in_char,
    output xnce_pkg::xnce_desc_t     desc
);
    import xnce_pkg::*;

    logic        in_range;
    logic        special;
    logic [13:0] prod_h;
    logic [1:0]  hund;
    logic [7:0]  hund_x100;
    logic [7:0]  rem8;
    logic [6:0]  rem;
    logic [14:0] prod_t;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones7;

    // Decide pass-through or escape
    always_comb begin
        in_range = (in_char >= ChSpace && in_char <= ChNine) ||
                   (in_char >= ChLowA && in_char <= ChLowZ) ||
                   (in_char >= ChUpA && in_char <= ChUpZ);
        special  = (in_char == ChDquote) || (in_char == ChSquote) ||
                   (in_char == ChAmp);
    end

    // Split into digits by reciprocal multiplication (exact for 0..255)
    always_comb begin
        prod_h    = {6'd0, in_char} * 14'd41;
        hund      = prod_h[13:12];
        hund_x100 = {6'd0, hund} * 8'd100;
        rem8      = in_char - hund_x100;
        rem       = rem8[6:0];
        prod_t    = {8'd0, rem} * 15'd205;
        tens      = prod_t[14:11];
        tens_x10  = {3'd0, tens} * 7'd10;
        ones7     = rem - tens_x10;
    end

    // Pack the classified item
    always_comb begin
        desc.plain    = in_range && !special;
        desc.ch       = in_char;
        desc.has_hund = (in_char >= 8'd100);
        desc.has_tens = (in_char >= 8'd10);
        desc.hund     = hund;
        desc.tens     = tens;
        desc.ones     = ones7[3:0];
    end

endmodule
`default_nettype wire

// ===== rtl/xnce_fifo.sv =====
// Short queue of classified items between the front and back parts.
`default_nettype none
module xnce_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  xnce_pkg::xnce_desc_t      push_data,
    output logic                      full,
    input  wire logic                 pop,
    output xnce_pkg::xnce_desc_t      pop_data,
    output logic                      empty
);
    import xnce_pkg::*;

    xnce_desc_t       mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == QCntW'(QDepth));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/xnce_back.sv =====
// Back part: walks each queued item through its output bytes into a register.
`default_nettype none
module xnce_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  xnce_pkg::xnce_desc_t      head,
    input  wire logic                 head_valid,
    output logic                      head_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_char,
    output logic                      m_run_last
);
    import xnce_pkg::*;

    xnce_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic        can_load;
    logic        step;
    logic [7:0]  load_char;
    logic        load_last;

    assign can_load = !m_valid_reg || m_ready;
    assign step     = can_load && head_valid;

    // Next step of the sequence
    always_comb begin
        state_next = state_reg;
        if (step) begin
            case (state_reg)
                ST_AMP: begin
                    state_next = head.plain ? ST_AMP : ST_HASH;
                end
                ST_HASH: begin
                    if (head.has_hund) begin
                        state_next = ST_HUND;
                    end else if (head.has_tens) begin
                        state_next = ST_TENS;
                    end else begin
                        state_next = ST_ONES;
                    end
                end
                ST_HUND: state_next = ST_TENS;
                ST_TENS: state_next = ST_ONES;
                ST_ONES: state_next = ST_SEMI;
                ST_SEMI: state_next = ST_AMP;
                default: state_next = ST_AMP;
            endcase
        end
    end

    // Select the byte for this step and drop the item on its last byte
    always_comb begin
        load_char = ChAmp;
        load_last = 1'b0;
        case (state_reg)
            ST_AMP: begin
                load_char = head.plain ? head.ch : ChAmp;
                load_last = head.plain;
            end
            ST_HASH: load_char = ChHash;
            ST_HUND: load_char = ChZero + {6'd0, head.hund};
            ST_TENS: load_char = ChZero + {4'd0, head.tens};
            ST_ONES: load_char = ChZero + {4'd0, head.ones};
            ST_SEMI: begin
                load_char = ChSemi;
                load_last = 1'b1;
            end
            default: begin
                load_char = ChAmp;
                load_last = 1'b0;
            end
        endcase
        head_pop = step && load_last;
    end

    // Hold the output until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (can_load) begin
            m_valid_next = head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_AMP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            char_reg <= load_char;
            last_reg <= load_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_char = char_reg;
    assign m_run_last = last_reg;

endmodule
`default_nettype wire

// ===== rtl/xml_numeric_char_escaper_top.sv =====
// Top level of the XML numeric character escaper.
//
//  Channel  Ports                           Carries
//  input    s_valid s_ready s_in_char       one raw text byte
//  result   m_valid m_ready m_out_char      one escaped byte,
//           m_run_last                      last flag on final byte of each item
//
// Plain bytes pass the queue register and then the output register, one per cycle
// while m_ready is high. An escaped byte yields four to six result bytes, one per
// cycle, set by the back-end sequencer. The item being escaped stays at the head
// of the two-entry queue, so one more byte is taken and then s_ready drops until
// the last byte of the run is loaded into the output register.
// Reset (aresetn low at a clock edge) empties the queue and the output register.
// Either side may stall at any time without losing or repeating bytes.
`default_nettype none
module xml_numeric_char_escaper_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_char,
    output logic            m_run_last
);
    import xnce_pkg::*;

    xnce_desc_t front_desc;
    xnce_desc_t head;
    logic       q_full;
    logic       q_empty;
    logic       head_pop;

    assign s_ready = !q_full;

    // Classify the incoming byte
    xnce_front u_front (
        .in_char (s_in_char),
        .desc    (front_desc)
    );

    // Queue classified items
    xnce_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (head_pop),
        .pop_data  (head),
        .empty     (q_empty)
    );

    // Emit the output bytes
    xnce_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!q_empty),
        .head_pop   (head_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_run_last (m_run_last)
    );

endmodule
`default_nettype wire
